>>> rtl/dual_range_gated_average_fusion_defines.svh
// Assertion macros for the dual range fusion block.
// Each use names a label, an antecedent and a consequent; clk and rst of the
// using module clock and disable the check.
`ifndef DUAL_RANGE_GATED_AVERAGE_FUSION_DEFINES_SVH
`define DUAL_RANGE_GATED_AVERAGE_FUSION_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define DRGAF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");
// Next-cycle implication
`define DRGAF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");
`else
`define DRGAF_ASSERT_IMP(lbl, ante, cons)
`define DRGAF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/drgaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package drgaf_pkg;

  // Configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Register indexes (byte address 4*index)
  localparam logic [2:0] REG_SONAR_MIN   = 3'd0;
  localparam logic [2:0] REG_SONAR_MAX   = 3'd1;
  localparam logic [2:0] REG_TOF_MIN     = 3'd2;
  localparam logic [2:0] REG_TOF_MAX     = 3'd3;
  localparam logic [2:0] REG_WINDOW_LEN  = 3'd4;
  localparam logic [2:0] REG_RECORDS     = 3'd5;
  localparam logic [2:0] REG_TOF_WEIGHT  = 3'd6;

  // Register widths
  localparam int SONAR_LIM_W = 12;
  localparam int TOF_LIM_W   = 16;
  localparam int WLEN_W      = 5;
  localparam int RPR_W       = 5;
  localparam int WEIGHT_W    = 9;

  // Register reset values
  localparam logic [SONAR_LIM_W-1:0] SONAR_MIN_RST  = 12'd150;
  localparam logic [SONAR_LIM_W-1:0] SONAR_MAX_RST  = 12'd3000;
  localparam logic [TOF_LIM_W-1:0]   TOF_MIN_RST    = 16'd10;
  localparam logic [TOF_LIM_W-1:0]   TOF_MAX_RST    = 16'd500;
  localparam logic [WLEN_W-1:0]      WINDOW_LEN_RST = 5'd20;
  localparam logic [RPR_W-1:0]       RECORDS_RST    = 5'd5;
  localparam logic [WEIGHT_W-1:0]    TOF_WEIGHT_RST = 9'd192;

  // Field widths
  localparam int SONAR_CODE_W = 10;
  localparam int TOF_RANGE_W  = 16;
  localparam int SON_AVG_W    = 16;
  localparam int TOF_AVG_W    = 20;
  localparam int FUSED_W      = 16;

  // Sonar gate: code*127 against limit*10 (tenths of a millimetre)
  localparam int SONAR_SCALED_W = 17;
  localparam logic [SONAR_SCALED_W-1:0] SONAR_CODE_X10 = 17'd127;
  localparam logic [SONAR_SCALED_W-1:0] MM_X10         = 17'd10;

  // Window average scaling: sum*NUM / (count*DEN)
  localparam int SCALE_W  = 11;
  localparam int DSCALE_W = 3;
  localparam logic [SCALE_W-1:0]  SONAR_NUM_SCALE = 11'd1016;
  localparam logic [DSCALE_W-1:0] SONAR_DEN_SCALE = 3'd5;
  localparam logic [SCALE_W-1:0]  TOF_NUM_SCALE   = 11'd16;
  localparam logic [DSCALE_W-1:0] TOF_DEN_SCALE   = 3'd1;

  // Fusion, Q8 weight
  localparam int Q8_SHIFT = 8;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;
  localparam int FUSE_NUM_W = WEIGHT_W + TOF_AVG_W;

  // Sequencer to lane request
  typedef struct packed {
    logic step;       // take a sample this cycle
    logic sample_ok;  // sample passed the gate
    logic mean;       // average and clear the record store
  } lane_cmd_t;

  // Lane status back to the sequencer
  typedef struct packed {
    logic busy;
    logic ready;
  } lane_stat_t;

endpackage

`default_nettype wire

>>> rtl/drgaf_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle
module drgaf_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] dq;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Shift in the next dividend bit and trial-subtract
  assign trial = {rem, dq[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};
  assign quot  = dq;

  // Iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(NUM_W - 1);
      end else if (run) begin
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dq    <= num;
      den_r <= den;
      rem   <= '0;
    end else if (run) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      dq  <= {dq[NUM_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

>>> rtl/drgaf_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// One sensor channel: window accumulation, window average, record store
// and store mean, sharing one iterative divider.
module drgaf_lane #(
  parameter int SAMPLE_W = 16,
  parameter int AVG_W    = 20,
  parameter int DEPTH    = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  drgaf_pkg::lane_cmd_t          cmd,
  input  logic [SAMPLE_W-1:0]           sample,
  input  logic [drgaf_pkg::SCALE_W-1:0] num_scale,
  input  logic [drgaf_pkg::DSCALE_W-1:0] den_scale,
  input  logic [drgaf_pkg::WLEN_W-1:0]  window_length,
  input  logic [drgaf_pkg::RPR_W-1:0]   records_per_result,
  output drgaf_pkg::lane_stat_t         stat,
  output logic [AVG_W-1:0]              window_avg,
  output logic [AVG_W-1:0]              store_mean
);

  import drgaf_pkg::*;

  localparam int SUM_W   = SAMPLE_W + WLEN_W;
  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RSUM_W  = AVG_W + FILL_W;
  localparam int WDIV_W  = SUM_W + SCALE_W;
  localparam int DIV_W   = (WDIV_W > RSUM_W) ? WDIV_W : RSUM_W;
  localparam int WDEN_W  = WLEN_W + DSCALE_W;
  localparam int DEN_W   = (WDEN_W > FILL_W) ? WDEN_W : FILL_W;
  localparam int CMP_W   = (FILL_W > RPR_W) ? FILL_W : RPR_W;
  localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(DEPTH);

  localparam logic [2:0] L_IDLE  = 3'd0;
  localparam logic [2:0] L_MUL   = 3'd1;
  localparam logic [2:0] L_WDIV  = 3'd2;
  localparam logic [2:0] L_STORE = 3'd3;
  localparam logic [2:0] L_WALK  = 3'd4;
  localparam logic [2:0] L_MDIV  = 3'd5;
  localparam logic [2:0] L_MEAN  = 3'd6;

  logic [2:0]        state;
  logic [WLEN_W-1:0] acc_cnt;
  logic [WLEN_W-1:0] tot_cnt;
  logic [SUM_W-1:0]  win_sum;
  logic [FILL_W-1:0] fill;
  logic              ready;
  logic [FILL_W-1:0] idx;
  logic              rd_pend;
  logic [RSUM_W-1:0] rec_sum;
  logic [AVG_W-1:0]  mem [DEPTH];
  logic [AVG_W-1:0]  rdata;

  logic [WLEN_W-1:0] acc_inc;
  logic [WLEN_W-1:0] tot_inc;
  logic [SUM_W-1:0]  sum_inc;
  logic              close;
  logic              room;
  logic              mem_we;
  logic              rd_en;
  logic [WDIV_W-1:0] wprod;
  logic [WDEN_W-1:0] wden;
  logic              div_start;
  logic [DIV_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_done;
  logic [DIV_W-1:0]  div_quot;

  // Window accumulation for this sample
  assign acc_inc = acc_cnt + WLEN_W'(cmd.sample_ok);
  assign tot_inc = tot_cnt + 1'b1;
  assign sum_inc = win_sum + (cmd.sample_ok ? SUM_W'(sample) : '0);
  assign close   = tot_inc >= window_length;

  // Store has room below both the record limit and the depth
  assign room = (CMP_W'(fill) < CMP_W'(records_per_result)) && (fill < DEPTH_FILL);

  assign mem_we = (state == L_STORE) && room;
  assign rd_en  = (state == L_WALK) && (idx < fill);

  // Divider operands: window average or store mean
  assign wprod = win_sum * num_scale;
  assign wden  = acc_cnt * den_scale;

  always_comb begin
    div_start = 1'b0;
    if (state == L_MUL) begin
      div_start = (acc_cnt != '0);
    end else if (state == L_WALK) begin
      div_start = !rd_en && !rd_pend && (fill != '0);
    end
  end

  assign div_num = (state == L_MUL) ? DIV_W'(wprod) : DIV_W'(rec_sum);
  assign div_den = (state == L_MUL) ? DEN_W'(wden)  : DEN_W'(fill);

  drgaf_div #(
    .NUM_W (DIV_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Lane sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= L_IDLE;
      acc_cnt    <= '0;
      tot_cnt    <= '0;
      win_sum    <= '0;
      fill       <= '0;
      ready      <= 1'b0;
      rd_pend    <= 1'b0;
      window_avg <= '0;
    end else begin
      case (state)
        L_IDLE: begin
          if (cmd.step) begin
            acc_cnt <= acc_inc;
            tot_cnt <= tot_inc;
            win_sum <= sum_inc;
            if (close) begin
              state <= L_MUL;
            end
          end else if (cmd.mean) begin
            rd_pend <= 1'b0;
            state   <= L_WALK;
          end
        end
        L_MUL: begin
          // start the division if any sample passed, and open a fresh window
          acc_cnt <= '0;
          tot_cnt <= '0;
          win_sum <= '0;
          if (acc_cnt == '0) begin
            window_avg <= '0;
            state      <= L_STORE;
          end else begin
            state <= L_WDIV;
          end
        end
        L_WDIV: begin
          if (div_done) begin
            window_avg <= div_quot[AVG_W-1:0];
            state      <= L_STORE;
          end
        end
        L_STORE: begin
          // append the record, or drop it and flag the store as full
          if (room) begin
            fill <= fill + 1'b1;
          end else begin
            ready <= 1'b1;
          end
          state <= L_IDLE;
        end
        L_WALK: begin
          rd_pend <= rd_en;
          if (!rd_en && !rd_pend) begin
            state <= (fill == '0) ? L_MEAN : L_MDIV;
          end
        end
        L_MDIV: begin
          if (div_done) begin
            state <= L_MEAN;
          end
        end
        L_MEAN: begin
          fill  <= '0;
          ready <= 1'b0;
          state <= L_IDLE;
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

  // Walk address, running sum and mean result
  always_ff @(posedge clk) begin
    if (state == L_IDLE) begin
      idx     <= '0;
      rec_sum <= '0;
    end else if (state == L_WALK) begin
      if (rd_en) begin
        idx <= idx + 1'b1;
      end
      if (rd_pend) begin
        rec_sum <= rec_sum + RSUM_W'(rdata);
      end
    end
    if (state == L_WALK && !rd_en && !rd_pend && fill == '0) begin
      store_mean <= '0;
    end else if (state == L_MDIV && div_done) begin
      store_mean <= div_quot[AVG_W-1:0];
    end
  end

  // Record store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill[ADDR_W-1:0]] <= window_avg;
    end
    if (rd_en) begin
      rdata <= mem[idx[ADDR_W-1:0]];
    end
  end

  assign stat.busy  = (state != L_IDLE);
  assign stat.ready = ready;

endmodule

`default_nettype wire

>>> rtl/drgaf_merge.sv
`timescale 1ns / 1ps
`default_nettype none

// Weighted fusion of the two store means: (w*tof + (256-w)*sonar) >> 8
module drgaf_merge (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [drgaf_pkg::WEIGHT_W-1:0]  weight,
  input  logic [drgaf_pkg::SON_AVG_W-1:0] sonar_mean,
  input  logic [drgaf_pkg::TOF_AVG_W-1:0] tof_mean,
  output logic                            done,
  output logic [drgaf_pkg::FUSED_W-1:0]   fused_mm,
  output logic                            positive
);

  import drgaf_pkg::*;

  localparam int PS_W  = WEIGHT_W + SON_AVG_W;
  localparam int TOP_B = Q8_SHIFT + FUSED_W;

  logic [WEIGHT_W-1:0]   w_sat;
  logic [WEIGHT_W-1:0]   w_rest;
  logic [FUSE_NUM_W-1:0] prod_t;
  logic [PS_W-1:0]       prod_s;
  logic [FUSE_NUM_W-1:0] num;
  logic                  v1;

  // Saturate the weight at one
  assign w_sat  = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
  assign w_rest = WEIGHT_ONE - w_sat;
  assign num    = prod_t + FUSE_NUM_W'(prod_s);

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      done <= v1;
    end
  end

  // Multiply, then add, shift and saturate
  always_ff @(posedge clk) begin
    if (start) begin
      prod_t <= w_sat * tof_mean;
      prod_s <= w_rest * sonar_mean;
    end
    if (v1) begin
      fused_mm <= (|num[FUSE_NUM_W-1:TOP_B]) ? '1 : num[TOP_B-1:Q8_SHIFT];
      positive <= (num != '0);
    end
  end

endmodule

`default_nettype wire

>>> rtl/dual_range_gated_average_fusion.sv
// A closing window adds a window-average division (time-of-flight divider, one quotient
// bit per cycle over 32 bits); a fused result adds a record walk of one entry per cycle,
// a mean division in each lane and the fusion stages.
// A new request is taken only on return to idle.
// Reset: synchronous; clears counters, sums, fill counts, ready flags and registers to
// defaults; record stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "dual_range_gated_average_fusion_defines.svh"

module dual_range_gated_average_fusion #(
  parameter int RECORD_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [drgaf_pkg::PADDR_W-1:0]      paddr,
  input  logic [drgaf_pkg::PDATA_W-1:0]      pwdata,
  output logic [drgaf_pkg::PDATA_W-1:0]      prdata,
  output logic                               pready,
  // sample requests
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic [drgaf_pkg::SONAR_CODE_W-1:0] sonar_code,
  input  logic [drgaf_pkg::TOF_RANGE_W-1:0]  tof_range_mm,
  // result requests
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic                               laser_indicator,
  output logic                               fused_ready,
  output logic [drgaf_pkg::FUSED_W-1:0]      fused_mm_q4,
  output logic                               fused_positive,
  output logic [drgaf_pkg::SON_AVG_W-1:0]    sonar_window_avg_q4,
  output logic [drgaf_pkg::TOF_AVG_W-1:0]    tof_window_avg_q4
);

  import drgaf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STEP = 3'd1;
  localparam logic [2:0] S_MEAN = 3'd2;
  localparam logic [2:0] S_FUSE = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [SONAR_LIM_W-1:0] sonar_min_mm;
  logic [SONAR_LIM_W-1:0] sonar_max_mm;
  logic [TOF_LIM_W-1:0]   tof_min_mm;
  logic [TOF_LIM_W-1:0]   tof_max_mm;
  logic [WLEN_W-1:0]      window_length;
  logic [RPR_W-1:0]       records_per_result;
  logic [WEIGHT_W-1:0]    tof_weight_q8;

  logic [2:0]                state;
  logic                      accept;
  logic                      cfg_we;
  logic [SONAR_SCALED_W-1:0] sonar_scaled;
  logic [SONAR_SCALED_W-1:0] sonar_lo;
  logic [SONAR_SCALED_W-1:0] sonar_hi;
  logic                      sonar_ok;
  logic                      tof_ok;
  logic                      laser_hold;
  logic                      fused_hold;
  logic                      lanes_idle;
  logic                      both_ready;
  logic                      merge_start;
  logic                      merge_done;
  logic [FUSED_W-1:0]        merge_mm;
  logic                      merge_pos;
  logic                      out_load;

  lane_cmd_t  son_cmd;
  lane_cmd_t  tof_cmd;
  lane_stat_t son_stat;
  lane_stat_t tof_stat;

  logic [SON_AVG_W-1:0] son_win_avg;
  logic [SON_AVG_W-1:0] son_mean;
  logic [TOF_AVG_W-1:0] tof_win_avg;
  logic [TOF_AVG_W-1:0] tof_mean;

  // Register writes
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sonar_min_mm       <= SONAR_MIN_RST;
      sonar_max_mm       <= SONAR_MAX_RST;
      tof_min_mm         <= TOF_MIN_RST;
      tof_max_mm         <= TOF_MAX_RST;
      window_length      <= WINDOW_LEN_RST;
      records_per_result <= RECORDS_RST;
      tof_weight_q8      <= TOF_WEIGHT_RST;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_SONAR_MIN:  sonar_min_mm       <= pwdata[SONAR_LIM_W-1:0];
        REG_SONAR_MAX:  sonar_max_mm       <= pwdata[SONAR_LIM_W-1:0];
        REG_TOF_MIN:    tof_min_mm         <= pwdata[TOF_LIM_W-1:0];
        REG_TOF_MAX:    tof_max_mm         <= pwdata[TOF_LIM_W-1:0];
        REG_WINDOW_LEN: window_length      <= pwdata[WLEN_W-1:0];
        REG_RECORDS:    records_per_result <= pwdata[RPR_W-1:0];
        REG_TOF_WEIGHT: tof_weight_q8      <= pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (paddr[4:2])
      REG_SONAR_MIN:  prdata = PDATA_W'(sonar_min_mm);
      REG_SONAR_MAX:  prdata = PDATA_W'(sonar_max_mm);
      REG_TOF_MIN:    prdata = PDATA_W'(tof_min_mm);
      REG_TOF_MAX:    prdata = PDATA_W'(tof_max_mm);
      REG_WINDOW_LEN: prdata = PDATA_W'(window_length);
      REG_RECORDS:    prdata = PDATA_W'(records_per_result);
      REG_TOF_WEIGHT: prdata = PDATA_W'(tof_weight_q8);
      default:        prdata = '0;
    endcase
  end

  // Range gates; sonar compared in tenths of a millimetre
  assign sonar_scaled = SONAR_SCALED_W'(sonar_code) * SONAR_CODE_X10;
  assign sonar_lo     = SONAR_SCALED_W'(sonar_min_mm) * MM_X10;
  assign sonar_hi     = SONAR_SCALED_W'(sonar_max_mm) * MM_X10;
  assign sonar_ok     = (sonar_scaled < sonar_hi) && (sonar_scaled > sonar_lo);
  assign tof_ok       = (tof_range_mm < tof_max_mm) && (tof_range_mm > tof_min_mm);

  // Handshake and lane requests
  assign sample_stall = (state != S_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign lanes_idle   = !son_stat.busy && !tof_stat.busy;
  assign both_ready   = son_stat.ready && tof_stat.ready;
  assign merge_start  = (state == S_MEAN) && lanes_idle;
  assign out_load     = (state == S_OUT) && (!result_valid || !result_stall);

  assign son_cmd.step      = accept;
  assign son_cmd.sample_ok = sonar_ok;
  assign son_cmd.mean      = (state == S_STEP) && lanes_idle && both_ready;
  assign tof_cmd.step      = accept;
  assign tof_cmd.sample_ok = tof_ok;
  assign tof_cmd.mean      = son_cmd.mean;

  drgaf_lane #(
    .SAMPLE_W (SONAR_CODE_W),
    .AVG_W    (SON_AVG_W),
    .DEPTH    (RECORD_DEPTH)
  ) u_sonar_lane (
    .clk                (clk),
    .rst                (rst),
    .cmd                (son_cmd),
    .sample             (sonar_code),
    .num_scale          (SONAR_NUM_SCALE),
    .den_scale          (SONAR_DEN_SCALE),
    .window_length      (window_length),
    .records_per_result (records_per_result),
    .stat               (son_stat),
    .window_avg         (son_win_avg),
    .store_mean         (son_mean)
  );

  drgaf_lane #(
    .SAMPLE_W (TOF_RANGE_W),
    .AVG_W    (TOF_AVG_W),
    .DEPTH    (RECORD_DEPTH)
  ) u_tof_lane (
    .clk                (clk),
    .rst                (rst),
    .cmd                (tof_cmd),
    .sample             (tof_range_mm),
    .num_scale          (TOF_NUM_SCALE),
    .den_scale          (TOF_DEN_SCALE),
    .window_length      (window_length),
    .records_per_result (records_per_result),
    .stat               (tof_stat),
    .window_avg         (tof_win_avg),
    .store_mean         (tof_mean)
  );

  drgaf_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .start      (merge_start),
    .weight     (tof_weight_q8),
    .sonar_mean (son_mean),
    .tof_mean   (tof_mean),
    .done       (merge_done),
    .fused_mm   (merge_mm),
    .positive   (merge_pos)
  );

  // Sequencer: step lanes, fuse when both stores are full, deliver result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      laser_hold   <= 1'b0;
      fused_hold   <= 1'b0;
    end else begin
      // raise valid on a fresh result, drop it once taken
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            laser_hold <= tof_ok;
            state      <= S_STEP;
          end
        end
        S_STEP: begin
          if (lanes_idle) begin
            fused_hold <= both_ready;
            state      <= both_ready ? S_MEAN : S_OUT;
          end
        end
        S_MEAN: begin
          if (lanes_idle) begin
            state <= S_FUSE;
          end
        end
        S_FUSE: begin
          if (merge_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register: load when the slot is free
  always_ff @(posedge clk) begin
    if (out_load) begin
      laser_indicator     <= laser_hold;
      fused_ready         <= fused_hold;
      fused_mm_q4         <= fused_hold ? merge_mm : '0;
      fused_positive      <= fused_hold && merge_pos;
      sonar_window_avg_q4 <= son_win_avg;
      tof_window_avg_q4   <= tof_win_avg;
    end
  end

  // Checks
  `DRGAF_ASSERT_IMP(a_result_from_out, $rose(result_valid), $past(state) == S_OUT)
  `DRGAF_ASSERT_IMP(a_idle_fields_zero, result_valid && !fused_ready, fused_mm_q4 == '0 && !fused_positive)
  `DRGAF_ASSERT_IMP(a_mean_when_ready, son_cmd.mean, both_ready && lanes_idle)
  `DRGAF_ASSERT_NXT(a_mean_starts_walk, son_cmd.mean, son_stat.busy && tof_stat.busy)
  `DRGAF_ASSERT_IMP(a_ready_cleared, merge_start, !son_stat.ready && !tof_stat.ready)

endmodule

`default_nettype wire
